// ===== sv/ellipse_trajectory_generator_core_defines.svh =====
// Assertion macros shared by the checker files of the ellipse generator.
`ifndef ELLIPSE_TRAJECTORY_GENERATOR_CORE_DEFINES_SVH
`define ELLIPSE_TRAJECTORY_GENERATOR_CORE_DEFINES_SVH

// Implication checked in the same cycle, sampled on clk and idle in reset.
`define ETG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ellipse generator check failed");

// Implication checked in the next cycle, sampled on clk and idle in reset.
`define ETG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ellipse generator check failed");

`endif

// ===== sv/etg_pkg.sv =====
package etg_pkg;

    // Phase accumulator and sine resolution.
    localparam int PHASE_BITS = 16;
    localparam int SINE_BITS  = 16;

    // Field widths.
    localparam int AXIS_W  = 20;
    localparam int STEP_W  = 16;
    localparam int OUT_W   = 20;

    // CORDIC on a 32-bit turn angle, x and y at scale 2^30.
    localparam int TURN_W       = 32;
    localparam int TURN_PAD     = TURN_W - PHASE_BITS;
    localparam int ANGLE_W      = TURN_W - 2;
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int GAIN_INV     = 652032874;

    // Rounding of the CORDIC result to the sine scale.
    localparam int SC_SHIFT = TURN_W - SINE_BITS;
    localparam int SC_HALF  = 1 << (SC_SHIFT - 1);
    localparam int AMP      = 1 << (SINE_BITS - 2);

    // Shared multiplier: unsigned axis times signed factor.
    localparam int MUL_B_W = (SINE_BITS > 18) ? SINE_BITS : 18;
    localparam int PROD_W  = AXIS_W + 1 + MUL_B_W;
    localparam int SAT_W   = PROD_W + 2;

    // Axis scaling constants, Q2.16, 18-bit signed.
    localparam int SHRINK_K   = 64881;
    localparam int GROW_K     = 66191;
    localparam int AXIS_FRAC  = 16;
    localparam int AXIS_HALF  = 1 << (AXIS_FRAC - 1);
    localparam int AXIS_MAX   = (1 << AXIS_W) - 1;

    // Product rounding back to Q4.16.
    localparam int OUT_FRAC = SINE_BITS - 2;
    localparam int OUT_HALF = 1 << (SINE_BITS - 3);
    localparam int OUT_MAX  = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN  = -(1 << (OUT_W - 1));

    // Reset values of the registers.
    localparam logic [AXIS_W-1:0] MAJOR_RESET  = AXIS_W'(6554);
    localparam logic [AXIS_W-1:0] MINOR_RESET  = AXIS_W'(3277);
    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(2048);
    localparam logic [AXIS_W-1:0] OFFSET_RESET = AXIS_W'(9830);

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_MAJOR_INIT,
        REG_MINOR_INIT,
        REG_PHASE_STEP,
        REG_VERT_OFFSET
    } etg_reg_idx_t;

    // Input word.
    typedef struct packed {
        logic restart;
        logic reading_valid;
        logic shrink_major;
        logic grow_major;
        logic shrink_minor;
        logic grow_minor;
    } etg_in_t;

    // Output word.
    typedef struct packed {
        logic signed [OUT_W-1:0] y_position;
        logic signed [OUT_W-1:0] z_position;
    } etg_out_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAJ_MUL,
        ST_MAJ_WB,
        ST_MIN_MUL,
        ST_MIN_WB,
        ST_ROT_GO,
        ST_ROTATE,
        ST_FOLD,
        ST_Y_MUL,
        ST_Y_WB,
        ST_Z_MUL,
        ST_Z_WB,
        ST_EMIT
    } etg_state_t;

    // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
    function automatic logic signed [Z_W-1:0] etg_atan(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = Z_W'(536870912);
            5'd1:  v = Z_W'(316933406);
            5'd2:  v = Z_W'(167458907);
            5'd3:  v = Z_W'(85004756);
            5'd4:  v = Z_W'(42667331);
            5'd5:  v = Z_W'(21419999);
            5'd6:  v = Z_W'(10721822);
            5'd7:  v = Z_W'(5364821);
            5'd8:  v = Z_W'(2683475);
            5'd9:  v = Z_W'(1341743);
            5'd10: v = Z_W'(670872);
            5'd11: v = Z_W'(335820);
            5'd12: v = Z_W'(167910);
            5'd13: v = Z_W'(83955);
            5'd14: v = Z_W'(41978);
            5'd15: v = Z_W'(20861);
            5'd16: v = Z_W'(10430);
            5'd17: v = Z_W'(5215);
            5'd18: v = Z_W'(2608);
            5'd19: v = Z_W'(1304);
            5'd20: v = Z_W'(652);
            5'd21: v = Z_W'(326);
            5'd22: v = Z_W'(163);
            5'd23: v = Z_W'(81);
            5'd24: v = Z_W'(41);
            5'd25: v = Z_W'(20);
            5'd26: v = Z_W'(10);
            5'd27: v = Z_W'(5);
            5'd28: v = Z_W'(3);
            5'd29: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Scale factor of one button pair; unity pairs are not written back.
    function automatic logic signed [MUL_B_W-1:0] etg_scale_k(input logic shrink,
                                                             input logic grow);
        logic signed [MUL_B_W-1:0] k;
        if (shrink && !grow) begin
            k = MUL_B_W'(SHRINK_K);
        end
        else begin
            k = MUL_B_W'(GROW_K);
        end
        return k;
    endfunction

    // Round a CORDIC output to the sine scale and clamp it to one amplitude.
    function automatic logic signed [SINE_BITS-1:0] etg_to_sine(
        input logic signed [XY_W-1:0] v
    );
        logic signed [XY_W:0] r;
        r = (XY_W+1)'(v) + (XY_W+1)'(SC_HALF);
        r = r >>> SC_SHIFT;
        if (r > (XY_W+1)'(AMP)) begin
            r = (XY_W+1)'(AMP);
        end
        else if (r < -(XY_W+1)'(AMP)) begin
            r = -(XY_W+1)'(AMP);
        end
        return SINE_BITS'(r);
    endfunction

    // Saturate a wide signed value to the output range.
    function automatic logic signed [OUT_W-1:0] etg_sat_out(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [OUT_W-1:0] r;
        if (v > SAT_W'(OUT_MAX)) begin
            r = OUT_W'(OUT_MAX);
        end
        else if (v < SAT_W'(OUT_MIN)) begin
            r = OUT_W'(OUT_MIN);
        end
        else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/ellipse_trajectory_generator_core.sv =====
// Channel  Direction  Handshake            Word
// in       input      in_valid/in_ready    etg_in_t: restart and button reading
// out      output     out_valid/out_ready  etg_out_t: y_position, z_position
// cfg      input      cfg_write            cfg_index, cfg_data
//
// The time of a normal word from acceptance to out_valid is set mostly by the
// 30-step CORDIC rotator plus four passes through the one shared multiplier.
// A restart word goes straight to the emit state. in_ready returns together
// with out_valid, so a new word is taken only once the last result is emitted.
// rst_n clears the sequencer and loads the register reset values at once.
// A full output register holds the sequencer in its last state until taken.
module ellipse_trajectory_generator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  etg_pkg::etg_in_t              in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output etg_pkg::etg_out_t             out_word,
    input  logic                          cfg_write,
    input  etg_pkg::etg_reg_idx_t         cfg_index,
    input  logic [etg_pkg::AXIS_W-1:0]    cfg_data
);
    import etg_pkg::*;

    etg_state_t                 state_reg, state_next;
    logic [AXIS_W-1:0]          offset_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [AXIS_W-1:0]          major_now_reg, major_now_next;
    logic [AXIS_W-1:0]          minor_now_reg, minor_now_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                       out_valid_reg, out_valid_next;
    etg_out_t                   out_word_reg;
    etg_in_t                    item_reg;
    logic signed [SINE_BITS-1:0] sin_reg, cos_reg;
    logic signed [OUT_W-1:0]    y_res_reg, z_res_reg;

    logic [AXIS_W-1:0]          mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic                       cor_start, cor_done;
    logic signed [XY_W-1:0]     cor_x, cor_y;
    logic [TURN_W-1:0]          turn;
    logic [1:0]                 quad;
    logic signed [XY_W-1:0]     cs, sn;
    logic                       accept, emit_free;
    logic                       major_en, minor_en;
    logic signed [PROD_W:0]     axis_sum, axis_shift;
    logic [AXIS_W-1:0]          axis_sat;
    logic signed [PROD_W:0]     out_sum, out_shift;
    logic signed [SAT_W-1:0]    z_sum, rst_sum;

    assign accept    = in_valid && in_ready;
    assign emit_free = !out_valid_reg || out_ready;
    assign major_en  = item_reg.reading_valid && (item_reg.shrink_major ^ item_reg.grow_major);
    assign minor_en  = item_reg.reading_valid && (item_reg.shrink_minor ^ item_reg.grow_minor);

    // Shared multiplier and rotator.
    etg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign turn = {phase_reg, {TURN_PAD{1'b0}}};

    etg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (turn[ANGLE_W-1:0]),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = in_word.restart ? ST_EMIT : ST_MAJ_MUL;
                end
            end
            ST_MAJ_MUL: state_next = ST_MAJ_WB;
            ST_MAJ_WB:  state_next = ST_MIN_MUL;
            ST_MIN_MUL: state_next = ST_MIN_WB;
            ST_MIN_WB:  state_next = ST_ROT_GO;
            ST_ROT_GO:  state_next = ST_ROTATE;
            ST_ROTATE:
            begin
                if (cor_done) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:    state_next = ST_Y_MUL;
            ST_Y_MUL:   state_next = ST_Y_WB;
            ST_Y_WB:    state_next = ST_Z_MUL;
            ST_Z_MUL:   state_next = ST_Z_WB;
            ST_Z_WB:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, rotator start, input ready.
    always_comb
    begin
        in_ready  = 1'b0;
        cor_start = 1'b0;
        mul_a     = major_now_reg;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_MAJ_MUL:
            begin
                mul_a = major_now_reg;
                mul_b = etg_scale_k(item_reg.shrink_major, item_reg.grow_major);
            end
            ST_MIN_MUL:
            begin
                mul_a = minor_now_reg;
                mul_b = etg_scale_k(item_reg.shrink_minor, item_reg.grow_minor);
            end
            ST_ROT_GO:  cor_start = 1'b1;
            ST_Y_MUL:
            begin
                mul_a = major_now_reg;
                mul_b = MUL_B_W'(sin_reg);
            end
            ST_Z_MUL:
            begin
                mul_a = minor_now_reg;
                mul_b = MUL_B_W'(cos_reg);
            end
            default:    in_ready = 1'b0;
        endcase
    end

    // Axis scaling: round, drop 16 fraction bits, saturate.
    assign axis_sum   = (PROD_W+1)'(prod) + (PROD_W+1)'(AXIS_HALF);
    assign axis_shift = axis_sum >>> AXIS_FRAC;
    assign axis_sat   = (axis_shift > (PROD_W+1)'(AXIS_MAX)) ? AXIS_W'(AXIS_MAX)
                                                             : AXIS_W'(axis_shift);

    // Product rounding back to Q4.16.
    assign out_sum   = (PROD_W+1)'(prod) + (PROD_W+1)'(OUT_HALF);
    assign out_shift = out_sum >>> OUT_FRAC;
    assign z_sum     = SAT_W'($signed({1'b0, offset_reg})) + SAT_W'(out_shift);
    assign rst_sum   = SAT_W'($signed({1'b0, offset_reg}))
                     + SAT_W'($signed({1'b0, minor_now_reg}));

    // Quadrant fold of the rotator result.
    assign quad = turn[TURN_W-1 -: 2];

    always_comb
    begin
        unique case (quad)
            2'd0:
            begin
                cs = cor_x;
                sn = cor_y;
            end
            2'd1:
            begin
                cs = -cor_y;
                sn = cor_x;
            end
            2'd2:
            begin
                cs = -cor_x;
                sn = -cor_y;
            end
            default:
            begin
                cs = cor_y;
                sn = -cor_x;
            end
        endcase
    end

    // Axis state: a register write reloads the axis, otherwise scaling applies.
    always_comb
    begin
        major_now_next = major_now_reg;
        minor_now_next = minor_now_reg;
        if (cfg_write && cfg_index == REG_MAJOR_INIT) begin
            major_now_next = cfg_data;
        end
        else if (state_reg == ST_MAJ_WB && major_en) begin
            major_now_next = axis_sat;
        end
        if (cfg_write && cfg_index == REG_MINOR_INIT) begin
            minor_now_next = cfg_data;
        end
        else if (state_reg == ST_MIN_WB && minor_en) begin
            minor_now_next = axis_sat;
        end
    end

    // Phase: cleared by restart, advanced once per normal word.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && in_word.restart) begin
            phase_next = '0;
        end
        else if (state_reg == ST_MIN_WB) begin
            phase_next = phase_reg + PHASE_BITS'(step_reg);
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_EMIT && emit_free) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            step_reg       <= STEP_RESET;
            offset_reg     <= OFFSET_RESET;
            major_now_reg  <= MAJOR_RESET;
            minor_now_reg  <= MINOR_RESET;
            phase_reg      <= '0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            major_now_reg <= major_now_next;
            minor_now_reg <= minor_now_next;
            phase_reg     <= phase_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    // The axis registers load the running axes directly.
                    REG_MAJOR_INIT:  ;
                    REG_MINOR_INIT:  ;
                    REG_PHASE_STEP:  step_reg       <= cfg_data[STEP_W-1:0];
                    REG_VERT_OFFSET: offset_reg     <= cfg_data;
                    default:         offset_reg     <= offset_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= in_word;
            if (in_word.restart) begin
                y_res_reg <= '0;
                z_res_reg <= etg_sat_out(rst_sum);
            end
        end
        if (state_reg == ST_FOLD) begin
            sin_reg <= etg_to_sine(sn);
            cos_reg <= etg_to_sine(cs);
        end
        if (state_reg == ST_Y_WB) begin
            y_res_reg <= etg_sat_out(SAT_W'(out_shift));
        end
        if (state_reg == ST_Z_WB) begin
            z_res_reg <= etg_sat_out(z_sum);
        end
        if (state_reg == ST_EMIT && emit_free) begin
            out_word_reg.y_position <= y_res_reg;
            out_word_reg.z_position <= z_res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== sv/etg_mul.sv =====
module etg_mul (
    input  logic                                 clk,
    input  logic [etg_pkg::AXIS_W-1:0]           a,
    input  logic signed [etg_pkg::MUL_B_W-1:0]   b,
    output logic signed [etg_pkg::PROD_W-1:0]    prod
);
    import etg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Unsigned axis times signed factor, product registered.
    assign prod_next = PROD_W'($signed({1'b0, a})) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/etg_cordic.sv =====
module etg_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [etg_pkg::ANGLE_W-1:0]         angle,
    output logic                                done,
    output logic signed [etg_pkg::XY_W-1:0]     x_out,
    output logic signed [etg_pkg::XY_W-1:0]     y_out
);
    import etg_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic signed [XY_W-1:0]   dx, dy;
    logic signed [Z_W-1:0]    at;
    logic                     last_iter;

    // One micro-rotation per cycle, each shifting by the iteration index.
    assign dx        = y_reg >>> iter_reg;
    assign dy        = x_reg >>> iter_reg;
    assign at        = etg_atan(iter_reg);
    assign last_iter = (iter_reg == ITER_W'(CORDIC_ITERS - 1));

    // Iteration control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
        end
        else if (busy_reg) begin
            iter_next = iter_reg + ITER_W'(1);
            if (last_iter) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Rotation datapath.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start) begin
            x_next = XY_W'(GAIN_INV);
            y_next = '0;
            z_next = $signed({{(Z_W - ANGLE_W){1'b0}}, angle});
        end
        else if (busy_reg) begin
            if (!z_reg[Z_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

// ===== sv/etg_checker.sv =====
`include "ellipse_trajectory_generator_core_defines.svh"

module etg_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  etg_pkg::etg_out_t    out_word
);
    import etg_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // A word that waits on the output side holds its value.
    `ETG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

    // The block is busy right after it takes a word.
    `ETG_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready)

    // No result appears in the cycle right after a word is taken.
    `ETG_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid))

    // A new result coincides with the block being ready for the next word.
    `ETG_ASSERT_NOW(a_ready_with_result, $rose(out_valid), in_ready)

endmodule

bind ellipse_trajectory_generator_core etg_checker u_etg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
